@@ rtl/soiu_pkg.sv @@
// shared types and constants for the strided offset index unit
// no dependencies
`default_nettype none
package soiu_pkg;
    localparam int NUM_SLOTS    = 6;
    localparam int MAX_RANK_DEF = 6;
    localparam int DW           = 32;
    localparam int RANK_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int QDEPTH       = 2;
    localparam int DIV_STEPS    = DW;
    localparam int CNT_W        = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] REG_RANK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NATURAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_4 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_5 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_6 = 3'd7;

    localparam logic [2:0] BAD_NONE = 3'd6;

    // one classified item between front and back
    typedef struct packed {
        logic              need_div;
        logic [RANK_W-1:0] rank;
        logic              natural;
        logic [DW-1:0]     offset;
        logic              ok;
        logic [2:0]        bad;
    } t_item;

    // back status toward the front and the config block
    typedef struct packed {
        logic sizing;
        logic size_ack;
    } t_back_status;
endpackage
`default_nettype wire

@@ rtl/soiu_queue.sv @@
// short queue of classified items between front and back
// depends on soiu_pkg
`default_nettype none
module soiu_queue import soiu_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_data
);
    localparam int PW = $clog2(QDEPTH);

    t_item            r_mem [QDEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QDEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/soiu_front.sv @@
// front end: accepts items, checks strides, bounds and index ranges
// depends on soiu_pkg
`default_nettype none
module soiu_front import soiu_pkg::*; #(
    parameter int MAX_RANK = MAX_RANK_DEF
) (
    input  wire logic              i_opcode,
    input  wire logic [DW-1:0]     i_offset,
    input  wire logic [DW-1:0]     i_index [NUM_SLOTS],
    input  wire logic [RANK_W-1:0] i_rank,
    input  wire logic              i_natural,
    input  wire logic [DW-1:0]     i_stride [NUM_SLOTS],
    input  wire logic [DW-1:0]     i_size [NUM_SLOTS],
    output t_item                  o_item
);
    localparam int LIM = (MAX_RANK < NUM_SLOTS) ? MAX_RANK : NUM_SLOTS;

    logic [RANK_W-1:0] act;
    logic [RANK_W-1:0] last;
    logic              zero;
    logic              found;
    logic [2:0]        bad;
    logic [RANK_W-1:0] s;

    always_comb begin
        act   = (i_rank > RANK_W'(LIM)) ? RANK_W'(LIM) : i_rank;
        last  = act - 1'b1;
        zero  = 1'b0;
        found = 1'b0;
        bad   = BAD_NONE;
        s     = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (RANK_W'(k) < act && i_stride[k] == '0) zero = 1'b1;
        end
        // first ordinal whose index reaches its dimension size
        for (int k = 0; k < NUM_SLOTS; k++) begin
            s = i_natural ? last - RANK_W'(k) : RANK_W'(k);
            if (!found && RANK_W'(k) < act && i_index[k] >= i_size[s]) begin
                found = 1'b1;
                bad   = 3'(k);
            end
        end
        o_item.rank     = act;
        o_item.natural  = i_natural;
        o_item.offset   = i_offset;
        o_item.need_div = !i_opcode && !zero && act != '0;
        if (zero) begin
            o_item.ok  = 1'b0;
            o_item.bad = BAD_NONE;
        end else if (!i_opcode) begin
            o_item.ok  = (act != '0) && (i_offset < i_stride[last]);
            o_item.bad = BAD_NONE;
        end else begin
            o_item.ok  = !found;
            o_item.bad = bad;
        end
    end
endmodule
`default_nettype wire

@@ rtl/soiu_back.sv @@
// back end: shared radix-2 divider for offset splitting and size table
// depends on soiu_pkg
`default_nettype none
module soiu_back import soiu_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_size_req,
    input  wire logic [DW-1:0] i_stride [NUM_SLOTS],
    output logic [DW-1:0]      o_size [NUM_SLOTS],
    output t_back_status       o_status,
    input  wire logic          i_head_valid,
    input  wire t_item         i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [DW-1:0]      o_index [NUM_SLOTS],
    output logic               o_in_bounds,
    output logic [2:0]         o_bad_ordinal
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SIZE = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    t_item             r_cur;
    logic [RANK_W-1:0] r_k;
    logic [RANK_W-1:0] r_s;
    logic [CNT_W-1:0]  r_cnt;
    logic [DW-1:0]     r_num, r_d, r_rem;
    logic [DW:0]       r_part;
    logic [DW-1:0]     r_idx  [NUM_SLOTS];
    logic [DW-1:0]     r_size [NUM_SLOTS];
    logic              r_out_valid;

    logic [DW:0]       part_sh;
    logic [DW+1:0]     diff;
    logic              ge;
    logic [DW:0]       n_part;
    logic [DW-1:0]     n_num;
    logic              slot_free, load, last_step;
    logic              direct;
    t_item             src;
    logic [DW-1:0]     fin_idx [NUM_SLOTS];
    logic [RANK_W-1:0] pos_last, pos_q, k_dn;

    // one quotient bit per cycle
    always_comb begin
        part_sh = {r_part[DW-1:0], r_num[DW-1]};
        diff    = {1'b0, part_sh} - {2'b00, r_d};
        ge      = ~diff[DW+1];
        n_part  = ge ? diff[DW:0] : part_sh;
        n_num   = {r_num[DW-2:0], ge};
    end

    assign last_step = (r_cnt == CNT_W'(DIV_STEPS-1));
    assign slot_free = !r_out_valid || i_ready;
    assign k_dn      = r_k - 1'b1;
    assign pos_q     = r_cur.natural ? r_cur.rank - 1'b1 - r_k : r_k;

    // items with nothing to divide leave straight from the queue head
    assign direct = (r_state == ST_IDLE) && !i_size_req && i_head_valid &&
                    !(i_head.need_div && i_head.rank > RANK_W'(1));
    assign src    = (r_state == ST_FIN) ? r_cur : i_head;
    assign load   = slot_free && (direct || r_state == ST_FIN);

    always_comb begin
        pos_last = src.natural ? src.rank - 1'b1 : '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            fin_idx[k] = (r_state == ST_FIN) ? r_idx[k] : '0;
        end
        if (src.need_div) begin
            fin_idx[pos_last] = (r_state == ST_FIN) ? r_rem : src.offset;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_size_req) begin
                    n_state = ST_SIZE;
                end else if (i_head_valid) begin
                    if (!direct) begin
                        o_pop   = 1'b1;
                        n_state = ST_DIV;
                    end else if (slot_free) begin
                        o_pop = 1'b1;
                    end
                end
            end
            ST_SIZE: begin
                if (last_step && r_s == RANK_W'(NUM_SLOTS-1)) n_state = ST_IDLE;
            end
            ST_DIV: begin
                if (last_step && k_dn == '0) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cnt  <= '0;
                r_part <= '0;
                if (i_size_req) begin
                    r_size[0] <= i_stride[0];
                    r_s       <= RANK_W'(1);
                    r_num     <= i_stride[1];
                    r_d       <= i_stride[0];
                end else if (o_pop && !direct) begin
                    r_cur <= i_head;
                    r_k   <= i_head.rank - 1'b1;
                    r_num <= i_head.offset;
                    r_d   <= i_stride[i_head.rank - 2'd2];
                    for (int k = 0; k < NUM_SLOTS; k++) r_idx[k] <= '0;
                end
            end
            ST_SIZE: begin
                r_cnt  <= r_cnt + 1'b1;
                r_part <= n_part;
                r_num  <= n_num;
                if (last_step) begin
                    r_size[r_s] <= n_num;
                    r_part      <= '0;
                    if (r_s != RANK_W'(NUM_SLOTS-1)) begin
                        r_s   <= r_s + 1'b1;
                        r_num <= i_stride[r_s + 1'b1];
                        r_d   <= i_stride[r_s];
                    end
                end
            end
            ST_DIV: begin
                r_cnt  <= r_cnt + 1'b1;
                r_part <= n_part;
                r_num  <= n_num;
                if (last_step) begin
                    r_idx[pos_q] <= n_num;
                    r_rem        <= n_part[DW-1:0];
                    r_k          <= k_dn;
                    r_part       <= '0;
                    r_num        <= n_part[DW-1:0];
                    r_d          <= i_stride[k_dn - 1'b1];
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
        if (load) begin
            for (int k = 0; k < NUM_SLOTS; k++) o_index[k] <= fin_idx[k];
            o_in_bounds   <= src.ok;
            o_bad_ordinal <= src.bad;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_size            = r_size;
    assign o_status.sizing   = (r_state == ST_SIZE);
    assign o_status.size_ack = (r_state == ST_IDLE) && i_size_req;

    // a held result is never overwritten
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(load && r_out_valid && !i_ready))
        else $error("result overwritten while stalled");
    // a division pass always has a digit left to produce
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_k != '0))
        else $error("division with no digit left");
    // user must rebuild the size table only with no item waiting (unenforced)
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIZE) |-> !i_head_valid)
        else $error("item queued during size pass");
    // a finished split is delivered in the cycle the slot frees
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && slot_free) |=> o_valid)
        else $error("finished item not delivered");
endmodule
`default_nettype wire

@@ rtl/strided_offset_index_unit_core.sv @@
// top level of the strided offset index unit: config registers, front, queue, back
// depends on soiu_pkg, soiu_front, soiu_queue, soiu_back
// opcode 1, zero-stride and rank-1 items skip the divider; opcode 0 of rank r>=2 is
//   split by the back's shared one-bit-per-cycle divider, one item at a time
// throughput: one item per cycle if unsplit and not stalled or held by a size pass
// reset: synchronous active low; registers go to rank 1, natural order, strides 1,
//   then a size pass (also after every config write) holds o_ready low
`default_nettype none
module strided_offset_index_unit_core import soiu_pkg::*; #(
    parameter int MAX_RANK = MAX_RANK_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [DW-1:0]        i_cfg_data,
    // input channel
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_opcode,
    input  wire logic [DW-1:0]        i_offset,
    input  wire logic [DW-1:0]        i_index_in_0,
    input  wire logic [DW-1:0]        i_index_in_1,
    input  wire logic [DW-1:0]        i_index_in_2,
    input  wire logic [DW-1:0]        i_index_in_3,
    input  wire logic [DW-1:0]        i_index_in_4,
    input  wire logic [DW-1:0]        i_index_in_5,
    // output channel
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [DW-1:0]             o_index_out_0,
    output logic [DW-1:0]             o_index_out_1,
    output logic [DW-1:0]             o_index_out_2,
    output logic [DW-1:0]             o_index_out_3,
    output logic [DW-1:0]             o_index_out_4,
    output logic [DW-1:0]             o_index_out_5,
    output logic                      o_in_bounds,
    output logic [2:0]                o_bad_ordinal
);
    // config registers
    logic [RANK_W-1:0] r_rank;
    logic              r_natural;
    logic [DW-1:0]     r_stride [NUM_SLOTS];
    logic              r_size_req;

    logic [DW-1:0] index_in  [NUM_SLOTS];
    logic [DW-1:0] index_out [NUM_SLOTS];
    logic [DW-1:0] size      [NUM_SLOTS];
    t_item         front_item, head;
    logic          q_full, q_valid, q_pop, push;
    t_back_status  bstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank     <= RANK_W'(1);
            r_natural  <= 1'b1;
            r_size_req <= 1'b1;
            for (int k = 0; k < NUM_SLOTS; k++) r_stride[k] <= DW'(1);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RANK:     r_rank      <= i_cfg_data[RANK_W-1:0];
                    REG_NATURAL:  r_natural   <= i_cfg_data[0];
                    REG_STRIDE_1: r_stride[0] <= i_cfg_data;
                    REG_STRIDE_2: r_stride[1] <= i_cfg_data;
                    REG_STRIDE_3: r_stride[2] <= i_cfg_data;
                    REG_STRIDE_4: r_stride[3] <= i_cfg_data;
                    REG_STRIDE_5: r_stride[4] <= i_cfg_data;
                    REG_STRIDE_6: r_stride[5] <= i_cfg_data;
                    default:      r_rank      <= r_rank;
                endcase
            end
            // any write may change a dimension size, so rebuild the table
            if (i_cfg_we) begin
                r_size_req <= 1'b1;
            end else if (bstat.size_ack) begin
                r_size_req <= 1'b0;
            end
        end
    end

    assign index_in[0] = i_index_in_0;
    assign index_in[1] = i_index_in_1;
    assign index_in[2] = i_index_in_2;
    assign index_in[3] = i_index_in_3;
    assign index_in[4] = i_index_in_4;
    assign index_in[5] = i_index_in_5;

    // no intake while the size table is stale or being rebuilt
    assign o_ready = !q_full && !r_size_req && !bstat.sizing;
    assign push    = i_valid && o_ready;

    soiu_front #(.MAX_RANK(MAX_RANK)) u_front (
        .i_opcode  (i_opcode),
        .i_offset  (i_offset),
        .i_index   (index_in),
        .i_rank    (r_rank),
        .i_natural (r_natural),
        .i_stride  (r_stride),
        .i_size    (size),
        .o_item    (front_item)
    );

    soiu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (head)
    );

    soiu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_size_req    (r_size_req),
        .i_stride      (r_stride),
        .o_size        (size),
        .o_status      (bstat),
        .i_head_valid  (q_valid),
        .i_head        (head),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_index       (index_out),
        .o_in_bounds   (o_in_bounds),
        .o_bad_ordinal (o_bad_ordinal)
    );

    assign o_index_out_0 = index_out[0];
    assign o_index_out_1 = index_out[1];
    assign o_index_out_2 = index_out[2];
    assign o_index_out_3 = index_out[3];
    assign o_index_out_4 = index_out[4];
    assign o_index_out_5 = index_out[5];
endmodule
`default_nettype wire
